/* rtl/lrta_pkg.sv */
// shared types and constants for the lcg ring three point average block
package lrta_pkg;

  localparam int VAL_W  = 31;  // ring value, seed and modulus width
  localparam int CFG_W  = 32;  // widest configuration register
  localparam int IDX_W  = 2;   // configuration register index width
  localparam int PROD_W = 63;  // multiplier times value
  localparam int DVD_W  = 64;  // full lcg sum before reduction
  localparam int STEP_W = 6;   // divider step counter
  localparam int SUM_W  = 33;  // three point window sum
  localparam int POS_W  = 5;   // position field
  localparam int THR_W  = 2;   // remainder in thirds

  // divide by three as a multiply by the scaled reciprocal, in two partial products
  localparam int HALF3_W    = 17;  // upper half of the window sum
  localparam int LOW3_W     = 16;  // lower half of the window sum
  localparam int RCP3_W     = 34;  // reciprocal width
  localparam int PART3_W    = 51;  // half sum times reciprocal
  localparam int ACC3_W     = 67;  // full sum times reciprocal
  localparam int RCP3_SHIFT = 35;  // quotient starts at this bit
  localparam logic [RCP3_W-1:0] RECIP_THREE = 34'h2_AAAA_AAAB;  // ceil(2^35 / 3)

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [IDX_W-1:0] REG_INCREMENT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MODULUS    = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] MULTIPLIER_RST = 32'd1;
  localparam logic [CFG_W-1:0] INCREMENT_RST  = 32'd0;
  localparam logic [VAL_W-1:0] MODULUS_RST    = 31'h7FFF_FFFF;

  // divider steps, two dividend bits per step
  localparam logic [STEP_W-1:0] MOD_STEPS = 6'd32;  // full 64 bit dividend

  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for a seed
    ST_MUL,    // multiply previous value
    ST_ADD,    // add increment
    ST_MOD,    // start reduction or bypass it
    ST_MWAIT,  // wait for reduction, write ring entry
    ST_RD,     // read third window entry
    ST_SUM,    // form window sum
    ST_MLO,    // low half of the sum times the reciprocal of three
    ST_MHI,    // high half of the sum times the reciprocal of three
    ST_LOAD    // load result register
  } state_t;

  typedef struct packed {
    logic                start;
    logic [STEP_W-1:0]   steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/lrta_ram.sv */
// generic single write port ram with registered read
module lrta_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lrta_divider.sv */
// iterative restoring remainder unit, two dividend bits per cycle
module lrta_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  lrta_pkg::div_cmd_t              cmd,
  input  logic [lrta_pkg::DVD_W-1:0]      dividend,
  input  logic [lrta_pkg::VAL_W-1:0]      divisor,
  output lrta_pkg::div_stat_t             stat,
  output logic [lrta_pkg::VAL_W-1:0]      remainder
);

  logic [lrta_pkg::DVD_W-1:0]  dvd;
  logic [lrta_pkg::VAL_W-1:0]  dsr;
  logic [lrta_pkg::VAL_W-1:0]  rem;
  logic [lrta_pkg::STEP_W-1:0] cnt;
  logic                        busy;
  logic                        done;

  logic [lrta_pkg::VAL_W:0]    r_a;
  logic [lrta_pkg::VAL_W:0]    r_b;
  logic [lrta_pkg::VAL_W-1:0]  r_a_next;
  logic [lrta_pkg::VAL_W-1:0]  r_b_next;
  logic                        ge_a;
  logic                        ge_b;

  always_comb begin
    r_a      = {rem, dvd[lrta_pkg::DVD_W-1]};
    ge_a     = r_a >= {1'b0, dsr};
    r_a_next = ge_a ? lrta_pkg::VAL_W'(r_a - {1'b0, dsr}) : r_a[lrta_pkg::VAL_W-1:0];
    r_b      = {r_a_next, dvd[lrta_pkg::DVD_W-2]};
    ge_b     = r_b >= {1'b0, dsr};
    r_b_next = ge_b ? lrta_pkg::VAL_W'(r_b - {1'b0, dsr}) : r_b[lrta_pkg::VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= cmd.steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == lrta_pkg::STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[lrta_pkg::DVD_W-3:0], 2'b00};
      rem <= r_b_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

/* rtl/lcg_ring_three_point_average.sv */
// top level: lcg ring fill followed by circular three point average emission
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  cfg     | in        | cfg_we (no wait)     | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready  | seed
//  out     | out       | out_valid / out_ready| position, raw_value, window_sum,
//          |           |                      | mean_whole, mean_thirds, last
//
//  one seed yields RING_LENGTH results, one item at a time
//  fill: each ring entry after the seed takes a multiply, an add, a divider start, the
//    divider steps and a write back; with a zero modulus, a multiply, an add and a write
//  emission: each result takes a ram read, a sum, two partial products against the
//    reciprocal of three and a load
//  rst is synchronous and clears control state only; the ring ram holds no reset value
//  a stalled output register holds the sequencer; a new seed is taken as soon as the
//    final result sits in the output register
module lcg_ring_three_point_average #(
  parameter int RING_LENGTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [lrta_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lrta_pkg::CFG_W-1:0]  cfg_data,
  // seed channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lrta_pkg::VAL_W-1:0]  seed,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lrta_pkg::POS_W-1:0]  position,
  output logic [lrta_pkg::VAL_W-1:0]  raw_value,
  output logic [lrta_pkg::SUM_W-1:0]  window_sum,
  output logic [lrta_pkg::VAL_W-1:0]  mean_whole,
  output logic [lrta_pkg::THR_W-1:0]  mean_thirds,
  output logic                        last
);

  localparam int AW = (RING_LENGTH > 1) ? $clog2(RING_LENGTH) : 1;
  localparam int CW = AW + 1;  // room for index plus two

  // configuration registers
  logic [lrta_pkg::CFG_W-1:0] multiplier;
  logic [lrta_pkg::CFG_W-1:0] increment;
  logic [lrta_pkg::VAL_W-1:0] modulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= lrta_pkg::MULTIPLIER_RST;
      increment  <= lrta_pkg::INCREMENT_RST;
      modulus    <= lrta_pkg::MODULUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrta_pkg::REG_MULTIPLIER: multiplier <= cfg_data;
        lrta_pkg::REG_INCREMENT:  increment  <= cfg_data;
        lrta_pkg::REG_MODULUS:    modulus    <= cfg_data[lrta_pkg::VAL_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // sequencer state
  lrta_pkg::state_t state, state_next;
  logic [AW-1:0]    fill_index;  // next ring entry to produce
  logic [AW-1:0]    emit_index;  // position being emitted

  // datapath registers
  logic [lrta_pkg::VAL_W-1:0]  prev;     // last value written to the ring
  logic [lrta_pkg::PROD_W-1:0] prod;
  logic [lrta_pkg::DVD_W-1:0]  full;
  logic [lrta_pkg::VAL_W-1:0]  first;    // ring entry 0, for the wrap
  logic [lrta_pkg::VAL_W-1:0]  second;   // ring entry 1, for the wrap
  logic [lrta_pkg::VAL_W-1:0]  win0;     // window entry at emit_index
  logic [lrta_pkg::VAL_W-1:0]  win1;     // window entry at emit_index + 1
  logic [lrta_pkg::VAL_W-1:0]  win2;     // window entry at emit_index + 2
  logic [lrta_pkg::SUM_W-1:0]  sum;
  logic [lrta_pkg::ACC3_W-1:0] acc3;     // window sum times the reciprocal of three

  // ring ram
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [lrta_pkg::VAL_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [lrta_pkg::VAL_W-1:0] ram_rdata;

  // modulo divider
  lrta_pkg::div_cmd_t         div_cmd;
  lrta_pkg::div_stat_t        div_stat;
  logic [lrta_pkg::DVD_W-1:0] div_dividend;
  logic [lrta_pkg::VAL_W-1:0] div_divisor;
  logic [lrta_pkg::VAL_W-1:0] div_rem;

  // control decoded from the state
  logic                       fill_write;  // a new ring value is ready this cycle
  logic [lrta_pkg::VAL_W-1:0] fill_value;
  logic                       fill_end;
  logic                       out_load;
  logic                       out_free;
  logic [CW-1:0]              third_index;
  logic [lrta_pkg::VAL_W-1:0] third_value;
  logic [lrta_pkg::SUM_W-1:0] sum_now;
  logic                       div_done;

  // divide by three: one half of the sum per cycle through a shared multiplier
  logic [lrta_pkg::HALF3_W-1:0] mul3_a;
  logic [lrta_pkg::PART3_W-1:0] part3;
  logic [lrta_pkg::VAL_W-1:0]   quo3;
  logic [lrta_pkg::SUM_W-1:0]   rem3;

  assign out_free    = !out_valid || out_ready;
  assign div_done    = div_stat.done && !div_stat.busy;
  assign fill_end    = fill_index == AW'(RING_LENGTH - 1);
  assign third_index = {1'b0, emit_index} + CW'(2);
  assign ram_raddr   = AW'(third_index);

  assign mul3_a = (state == lrta_pkg::ST_MHI) ? sum[lrta_pkg::SUM_W-1:lrta_pkg::LOW3_W]
                                              : {1'b0, sum[lrta_pkg::LOW3_W-1:0]};
  assign part3  = mul3_a * lrta_pkg::RECIP_THREE;
  assign quo3   = acc3[lrta_pkg::RCP3_SHIFT +: lrta_pkg::VAL_W];
  // remainder is the sum less three times the quotient, always 0 to 2
  assign rem3   = sum - {1'b0, quo3, 1'b0} - {2'b00, quo3};

  // third window entry wraps onto entries 0 and 1
  always_comb begin
    if (third_index < CW'(RING_LENGTH)) begin
      third_value = ram_rdata;
    end else if (third_index == CW'(RING_LENGTH)) begin
      third_value = first;
    end else begin
      third_value = second;
    end
    sum_now = lrta_pkg::SUM_W'(win0) + lrta_pkg::SUM_W'(win1) +
              lrta_pkg::SUM_W'(third_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = fill_index;
    ram_wdata     = div_rem;
    fill_write    = 1'b0;
    fill_value    = div_rem;
    out_load      = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.steps = lrta_pkg::MOD_STEPS;
    div_dividend  = full;
    div_divisor   = modulus;
    unique case (state)
      lrta_pkg::ST_IDLE: begin
        // no seed is taken while reset is held
        in_ready  = !rst;
        ram_waddr = '0;
        ram_wdata = seed;
        if (in_valid && !rst) begin
          ram_we     = 1'b1;
          state_next = lrta_pkg::ST_MUL;
        end
      end
      lrta_pkg::ST_MUL: begin
        state_next = lrta_pkg::ST_ADD;
      end
      lrta_pkg::ST_ADD: begin
        state_next = lrta_pkg::ST_MOD;
      end
      lrta_pkg::ST_MOD: begin
        if (modulus == '0) begin
          // modulus zero acts as two to the 31st: keep the low bits
          fill_value = full[lrta_pkg::VAL_W-1:0];
          ram_wdata  = full[lrta_pkg::VAL_W-1:0];
          ram_we     = 1'b1;
          fill_write = 1'b1;
          state_next = fill_end ? lrta_pkg::ST_RD : lrta_pkg::ST_MUL;
        end else begin
          div_cmd.start = 1'b1;
          state_next    = lrta_pkg::ST_MWAIT;
        end
      end
      lrta_pkg::ST_MWAIT: begin
        if (div_done) begin
          ram_we     = 1'b1;
          fill_write = 1'b1;
          state_next = fill_end ? lrta_pkg::ST_RD : lrta_pkg::ST_MUL;
        end
      end
      lrta_pkg::ST_RD: begin
        state_next = lrta_pkg::ST_SUM;
      end
      lrta_pkg::ST_SUM: begin
        state_next = lrta_pkg::ST_MLO;
      end
      lrta_pkg::ST_MLO: begin
        state_next = lrta_pkg::ST_MHI;
      end
      lrta_pkg::ST_MHI: begin
        state_next = lrta_pkg::ST_LOAD;
      end
      lrta_pkg::ST_LOAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = (emit_index == AW'(RING_LENGTH - 1)) ? lrta_pkg::ST_IDLE
                                                            : lrta_pkg::ST_RD;
        end
      end
      default: state_next = lrta_pkg::ST_IDLE;
    endcase
  end

  // index counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_index <= '0;
      emit_index <= '0;
    end else begin
      if (state == lrta_pkg::ST_IDLE && in_valid) begin
        fill_index <= AW'(1);
        emit_index <= '0;
      end else if (fill_write) begin
        fill_index <= fill_end ? '0 : fill_index + 1'b1;
      end else if (out_load) begin
        emit_index <= emit_index + 1'b1;
      end
    end
  end

  // fill and window datapath
  always_ff @(posedge clk) begin
    prod <= multiplier * prev;
    full <= lrta_pkg::DVD_W'(prod) + lrta_pkg::DVD_W'(increment);
    if (state == lrta_pkg::ST_IDLE && in_valid) begin
      prev  <= seed;
      first <= seed;
      win0  <= seed;
    end else if (fill_write) begin
      prev <= fill_value;
      if (fill_index == AW'(1)) begin
        second <= fill_value;
        win1   <= fill_value;
      end
    end
    if (state == lrta_pkg::ST_SUM) begin
      win2 <= third_value;
      sum  <= sum_now;
    end
    // quotient is the product shifted down past the reciprocal scale
    if (state == lrta_pkg::ST_MLO) begin
      acc3 <= lrta_pkg::ACC3_W'(part3);
    end else if (state == lrta_pkg::ST_MHI) begin
      acc3 <= acc3 + {part3, {lrta_pkg::LOW3_W{1'b0}}};
    end
    if (out_load) begin
      // slide the window by one
      win0 <= win1;
      win1 <= win2;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      position    <= lrta_pkg::POS_W'(emit_index);
      raw_value   <= win0;
      window_sum  <= sum;
      mean_whole  <= quo3;
      mean_thirds <= rem3[lrta_pkg::THR_W-1:0];
      last        <= emit_index == AW'(RING_LENGTH - 1);
    end
  end

  lrta_ram #(
    .WIDTH (lrta_pkg::VAL_W),
    .DEPTH (RING_LENGTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lrta_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .cmd       (div_cmd),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .remainder (div_rem)
  );

endmodule

/* rtl/lrta_checker.sv */
// port level checks for the lcg ring three point average block
module lrta_checker #(
  parameter int RING_LENGTH = 32
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_we,
  input logic [lrta_pkg::IDX_W-1:0]  cfg_index,
  input logic [lrta_pkg::CFG_W-1:0]  cfg_data,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [lrta_pkg::VAL_W-1:0]  seed,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lrta_pkg::POS_W-1:0]  position,
  input logic [lrta_pkg::VAL_W-1:0]  raw_value,
  input logic [lrta_pkg::SUM_W-1:0]  window_sum,
  input logic [lrta_pkg::VAL_W-1:0]  mean_whole,
  input logic [lrta_pkg::THR_W-1:0]  mean_thirds,
  input logic                        last
);

  // stalled result stays valid and keeps its position, raw value, window sum and last flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(raw_value)
      && $stable(window_sum) && $stable(last))
    else $error("stalled result changed");

  // whole part and thirds rebuild the window sum
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mean_thirds != 2'd3 &&
      window_sum == ({2'b00, mean_whole} * 33'd3 + {31'b0, mean_thirds}))
    else $error("mean does not match window sum");

  // final result sits at the last ring position
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> position == lrta_pkg::POS_W'(RING_LENGTH - 1))
    else $error("last flag at wrong position");

  // a seed is not taken the cycle after another seed
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("seed taken while run in progress");

endmodule

bind lcg_ring_three_point_average lrta_checker #(.RING_LENGTH(RING_LENGTH)) u_lrta_checker (.*);
